// ===== hdl/psdf_pkg.sv =====
// ----------------------------------------------------------------------------
// psdf_pkg: shared types and constants of the duplicate filter
// Field widths, stream word layout and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package psdf_pkg;

  localparam int ADDR_W              = 48;
  localparam int SEQ_W               = 16;
  localparam int IN_TDATA_W          = 64;  // address + sequence, byte aligned
  localparam int OUT_TDATA_W         = 8;   // two flags padded to one byte
  localparam int DEF_TABLE_ENTRIES   = 16;

  // stream word bit positions
  localparam int IN_ADDR_LSB         = 0;
  localparam int IN_SEQ_LSB          = ADDR_W;
  localparam int OUT_NEW_BIT         = 0;
  localparam int OUT_FULL_BIT        = 1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture an input word, restart the search
    logic step;    // read the next table entry
    logic finish;  // commit the decision, update table, post the result
  } psdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // entry under compare holds the source
    logic exhausted;  // every valid entry has been compared, no hit
    logic out_free;   // result register can take a word this cycle
  } psdf_status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } psdf_state_t;

endpackage

// ===== hdl/per_source_duplicate_filter_top.sv =====
// ----------------------------------------------------------------------------
// per_source_duplicate_filter_top: receive-side per-source duplicate filter
// Keeps each known source address with its last accepted sequence number.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (in_*): one word per received frame, source address in
//   in_tdata[47:0], sequence number in in_tdata[63:48].
//   Output stream (out_*): one word per input, is_new in out_tdata[0],
//   table_full in out_tdata[1], upper bits zero.
//   A known source gives is_new only for a strictly larger sequence, which
//   then replaces the stored one. An unknown source is appended and reported
//   new; with the table full it is reported new, not stored, table_full set.
// Timing
//   The table is one memory walked by one read port, one entry per cycle
//   with registered read data. A hit ends the walk at its entry; a miss
//   walks all stored entries, and with the table empty no entry is read.
//   One word is in work at a time: in_tready is high only between searches,
//   so a new word is taken only after the result of the last is committed.
// Reset and stall
//   rst_n (synchronous, active low) empties the table at once; no clearing
//   pass is needed. A stalled output holds its word; the next input may be
//   taken and searched meanwhile, and its result waits for the free slot.
// ----------------------------------------------------------------------------
module per_source_duplicate_filter_top #(
  parameter int TABLE_ENTRIES = psdf_pkg::DEF_TABLE_ENTRIES  // 1 .. 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psdf_pkg::IN_TDATA_W-1:0]   in_tdata,   // source_address, sequence_number
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psdf_pkg::OUT_TDATA_W-1:0]  out_tdata   // is_new, table_full, zero pad
);

  psdf_pkg::psdf_cmd_t    cmd;
  psdf_pkg::psdf_status_t st;

  psdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  psdf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/psdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// psdf_ctrl: search sequencer of the duplicate filter
// Accepts a word, walks the table one entry a cycle, then commits the result.
// ----------------------------------------------------------------------------
module psdf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  psdf_pkg::psdf_status_t st,
  output psdf_pkg::psdf_cmd_t    cmd
);

  psdf_pkg::psdf_state_t state_r, state_nxt;
  logic decided;

  assign in_tready = (state_r == psdf_pkg::ST_IDLE);
  assign decided   = st.hit || st.exhausted;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      psdf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = psdf_pkg::ST_SEARCH;
        end
      end
      psdf_pkg::ST_SEARCH: begin
        cmd.step = !decided;
        if (decided && st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = psdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psdf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psdf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/psdf_datapath.sv =====
// ----------------------------------------------------------------------------
// psdf_datapath: source table, compare logic and result register
// One read port walks the table; one write port updates or appends an entry.
// ----------------------------------------------------------------------------
module psdf_datapath #(
  parameter int TABLE_ENTRIES = psdf_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [psdf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  psdf_pkg::psdf_cmd_t               cmd,
  output psdf_pkg::psdf_status_t            st,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psdf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  logic [psdf_pkg::ADDR_W-1:0] mem_addr [TABLE_ENTRIES];
  logic [psdf_pkg::SEQ_W-1:0]  mem_seq  [TABLE_ENTRIES];

  logic [psdf_pkg::ADDR_W-1:0] key_addr_r, rd_addr_r;
  logic [psdf_pkg::SEQ_W-1:0]  key_seq_r, rd_seq_r;
  logic [CNT_W-1:0]            rd_idx_r, count_r;
  logic [IDX_W-1:0]            cmp_idx_r, wr_idx;
  logic                        cmp_v_r;
  logic                        out_valid_r, out_new_r, out_full_r;

  logic more, hit, seq_newer, tbl_full;
  logic wr_seq, wr_addr, res_new, res_full;

  assign more      = rd_idx_r < count_r;
  assign hit       = cmp_v_r && (rd_addr_r == key_addr_r);
  assign seq_newer = key_seq_r > rd_seq_r;
  assign tbl_full  = (count_r == FULL_CNT);

  assign st.hit       = hit;
  assign st.exhausted = !cmp_v_r && !more;
  assign st.out_free  = !out_valid_r || out_tready;

  // hit: refresh sequence if newer; miss: append unless full
  assign wr_seq   = cmd.finish && (hit ? seq_newer : !tbl_full);
  assign wr_addr  = cmd.finish && !hit && !tbl_full;
  assign wr_idx   = hit ? cmp_idx_r : count_r[IDX_W-1:0];
  assign res_new  = hit ? seq_newer : 1'b1;
  assign res_full = !hit && tbl_full;

  // table and read register
  always_ff @(posedge clk) begin
    if (wr_addr) begin
      mem_addr[wr_idx] <= key_addr_r;
    end
    if (wr_seq) begin
      mem_seq[wr_idx] <= key_seq_r;
    end
    if (cmd.step && more) begin
      rd_addr_r <= mem_addr[rd_idx_r[IDX_W-1:0]];
      rd_seq_r  <= mem_seq[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (cmd.load) begin
      key_addr_r <= in_tdata[psdf_pkg::IN_ADDR_LSB +: psdf_pkg::ADDR_W];
      key_seq_r  <= in_tdata[psdf_pkg::IN_SEQ_LSB +: psdf_pkg::SEQ_W];
    end
    if (cmd.finish) begin
      out_new_r  <= res_new;
      out_full_r <= res_full;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      cmp_v_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx_r <= '0;
        cmp_v_r  <= 1'b0;
      end else if (cmd.step) begin
        cmp_v_r <= more;
        if (more) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
      if (wr_addr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_tdata                         = '0;
    out_tdata[psdf_pkg::OUT_NEW_BIT]  = out_new_r;
    out_tdata[psdf_pkg::OUT_FULL_BIT] = out_full_r;
  end
  assign out_tvalid = out_valid_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_finish_posts : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("committed result not posted");

  a_hit_no_full : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && hit) |=> !out_full_r)
    else $error("full flag raised on a table hit");

endmodule

// ===== tb/per_source_duplicate_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// per_source_duplicate_filter_top_tb: self-checking bench of the duplicate filter
// Feeds frame words (source address, sequence number) into the input stream
// and checks every output word against a local model of the source table.
// A short table of directed frames covers the field extremes, equal, older
// and newer sequences, filling the table and the full-table case. Random
// frames follow in three idling phases. They are mostly repeats of known
// sources with newer, equal, older or arbitrary sequences, plus some
// unknown sources.
// ----------------------------------------------------------------------------
module per_source_duplicate_filter_top_tb;

  localparam int ADDR_W        = psdf_pkg::ADDR_W;
  localparam int SEQ_W         = psdf_pkg::SEQ_W;
  localparam int IN_TDATA_W    = psdf_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W   = psdf_pkg::OUT_TDATA_W;
  localparam int IN_ADDR_LSB   = psdf_pkg::IN_ADDR_LSB;
  localparam int IN_SEQ_LSB    = psdf_pkg::IN_SEQ_LSB;
  localparam int OUT_NEW_BIT   = psdf_pkg::OUT_NEW_BIT;
  localparam int OUT_FULL_BIT  = psdf_pkg::OUT_FULL_BIT;

  localparam int TABLE_ENTRIES  = psdf_pkg::DEF_TABLE_ENTRIES;
  localparam int RANDOM_FRAMES  = 800;
  localparam int LONG_HOLD      = 400;  // receiver hold-off, in cycles
  localparam int HOLD_AT_WORD   = 60;   // input word count that starts it
  localparam int DRAIN_CYCLES   = 40;   // a full search plus output slack

  // one verdict per frame word
  typedef struct packed {
    logic is_new;
    logic table_full;
  } verdict_t;

  // one line of the directed table
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    bit                typed;  // 1: verdict below is the expectation
    verdict_t          verdict;
  } frame_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // source_address, sequence_number
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // is_new, table_full, zero pad

  // local copy of the source table
  logic [ADDR_W-1:0] known_addr [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  known_seq  [TABLE_ENTRIES];
  int                known_count = 0;

  verdict_t   pending_verdicts [$];  // expected output words, oldest first
  frame_row_t directed_rows    [$];

  int mismatches     = 0;
  int src_idle_pct   = 30;
  int sink_stall_pct = 61;
  int in_words       = 0;   // accepted input words
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  per_source_duplicate_filter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // Table lookup: known source -> new only on a strictly larger sequence,
  // which replaces the stored one; unknown source -> appended, or flagged
  // full when no entry is left.
  function automatic verdict_t filter_decide(input logic [ADDR_W-1:0] addr,
                                             input logic [SEQ_W-1:0]  seq);
    verdict_t v;
    v = '{is_new: 1'b1, table_full: 1'b0};
    for (int k = 0; k < known_count; k++) begin
      if (known_addr[k] == addr) begin
        if (seq > known_seq[k]) begin
          known_seq[k] = seq;
        end else begin
          v.is_new = 1'b0;
        end
        return v;
      end
    end
    if (known_count < TABLE_ENTRIES) begin
      known_addr[known_count] = addr;
      known_seq[known_count]  = seq;
      known_count++;
    end else begin
      v.table_full = 1'b1;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one frame word; random idle cycles before it. The verdict is
  // queued at the edge where the word is taken.
  task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                            input verdict_t verdict);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_ADDR_LSB +: ADDR_W] = addr;
    word[IN_SEQ_LSB +: SEQ_W]   = seq;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    pending_verdicts.insert(pending_verdicts.size(), verdict);
  endtask

  // Sender goes quiet until every queued verdict has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                         input bit typed, input logic is_new, input logic table_full);
    frame_row_t r;
    r.addr    = addr;
    r.seq     = seq;
    r.typed   = typed;
    r.verdict = '{is_new: is_new, table_full: table_full};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Random frame: mostly known sources, some unknown ones.
  task automatic send_random_frame();
    int                pick;
    int                idx;
    int                span;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  old_seq;
    pick    = $urandom_range(99, 0);
    idx     = $urandom_range(known_count - 1, 0);
    addr    = known_addr[idx];
    old_seq = known_seq[idx];
    span    = (1 << SEQ_W) - 1 - int'(old_seq);
    if (pick < 40) begin
      // newer, small step; arbitrary once the entry is at the top
      if (span == 0) begin
        seq = SEQ_W'($urandom);
      end else begin
        seq = old_seq + SEQ_W'($urandom_range(span > 1500 ? 1500 : span, 1));
      end
    end else if (pick < 55) begin
      seq = old_seq;
    end else if (pick < 70) begin
      seq = (old_seq == 0) ? '0 : SEQ_W'($urandom_range(int'(old_seq) - 1, 0));
    end else if (pick < 85) begin
      seq = SEQ_W'($urandom);
    end else begin
      addr = ADDR_W'({$urandom, $urandom});
      seq  = SEQ_W'($urandom);
    end
    send_frame(addr, seq, filter_decide(addr, seq));
  endtask

  // Receiver: random stalls, plus one long hold-off so the block fills up
  // and drops in_tready while the sender keeps offering words.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && in_words == HOLD_AT_WORD) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_done  <= 1'b1;
    end else if ($urandom_range(99, 0) < sink_stall_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Output check: each word against the oldest queued verdict.
  always @(posedge clk) begin : out_check
    logic [OUT_TDATA_W-1:0] pad;
    verdict_t               want;
    if (rst_n && in_tvalid && in_tready) begin
      in_words <= in_words + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected output word, data", int'(out_tdata), 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[OUT_NEW_BIT] !== want.is_new) begin
          report_mismatch("is_new", int'(out_tdata[OUT_NEW_BIT]), int'(want.is_new));
        end
        if (out_tdata[OUT_FULL_BIT] !== want.table_full) begin
          report_mismatch("table_full", int'(out_tdata[OUT_FULL_BIT]),
                          int'(want.table_full));
        end
        pad = out_tdata;
        pad[OUT_NEW_BIT]  = 1'b0;
        pad[OUT_FULL_BIT] = 1'b0;
        if (pad !== '0) begin
          report_mismatch("pad bits", int'(pad), 0);
        end
      end
    end
  end

  initial begin
    verdict_t v;

    // Directed frames. Table starts empty; 16 distinct sources fill it.
    add_row(48'h0000_0000_0000, 16'h0000, 1, 1, 0);  // first source after reset
    add_row(48'h0000_0000_0000, 16'h0000, 1, 0, 0);  // equal sequence
    add_row(48'h0000_0000_0000, 16'h0001, 0, 0, 0);  // one larger
    add_row(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1, 1, 0);  // all ones, new source
    add_row(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1, 0, 0);  // top sequence repeated
    add_row(48'hFFFF_FFFF_FFFF, 16'h0000, 1, 0, 0);  // older, no wrap handling
    add_row(48'h0000_0000_0000, 16'hFFFF, 0, 0, 0);  // jump to the top
    add_row(48'hAAAA_AAAA_AAAA, 16'h1234, 1, 1, 0);
    add_row(48'h5555_5555_5555, 16'h8000, 1, 1, 0);
    for (int k = 0; k < 12; k++) begin
      add_row(48'h0200_0000_0000 + ADDR_W'(k), SEQ_W'(k * 5000), 1, 1, 0);
    end
    add_row(48'h0000_0000_0001, 16'h0005, 1, 1, 1);  // table full, unknown
    add_row(48'hFFFF_FFFF_FFFE, 16'hFFFF, 1, 1, 1);  // one bit off a stored source
    add_row(48'h0200_0000_000B, 16'hFFFF, 0, 0, 0);  // hit on the last entry
    add_row(48'h0000_0000_0000, 16'h0000, 1, 0, 0);  // hit on the first, full table

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      v = filter_decide(directed_rows[i].addr, directed_rows[i].seq);
      if (directed_rows[i].typed) begin
        v = directed_rows[i].verdict;
      end
      send_frame(directed_rows[i].addr, directed_rows[i].seq, v);
    end

    // Random frames in three idling phases, drained between them.
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          src_idle_pct   = 30;
          sink_stall_pct = 61;
        end
        1: begin
          src_idle_pct   = 61;
          sink_stall_pct = 30;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_FRAMES / 3; n++) begin
        send_random_frame();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/psdf_pkg.sv
hdl/psdf_ctrl.sv
hdl/psdf_datapath.sv
hdl/per_source_duplicate_filter_top.sv
tb/per_source_duplicate_filter_top_tb.sv
